// File: src/srts_pkg.sv
package srts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int POS_W = IDX_W + 2;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] rec_id;
    logic [63:0]        rec_name;
    logic [7:0]         rec_gender;
    logic [7:0]         rec_age;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_id;
    logic [63:0]        out_name;
    logic [7:0]         out_gender;
    logic [7:0]         out_age;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        name;
    logic [7:0]         gender;
    logic [7:0]         age;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       load;
    logic       clear;
    logic       sort_init;
    logic       rd_cur;
    logic       cur_take;
    logic       shift;
    logic       put;
    logic       sort_done;
    logic       srch_init;
    logic       probe;
    logic       go_low;
    logic       go_high;
    logic       set_res;
    logic [2:0] res_status;
    logic       emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       sorted;
    logic       i_lt_cnt;
    logic       gt;
    logic       j_is_one;
    logic       srch_over;
    logic       eq;
    logic       lt;
    logic       out_free;
  } sts_t;

endpackage

// File: src/srts_ram.sv
module srts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/srts_ctrl.sv
module srts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  srts_pkg::sts_t sts,
  output srts_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SORT_CHK, S_SORT_CUR, S_SORT_CMP, S_SORT_PUT, S_SRCH, S_PROBE
  } state_t;

  state_t state_r, state_nxt;
  logic   emit_pend_r, emit_pend_nxt;

  assign in_stall = !rst_n || (state_r != S_IDLE) || emit_pend_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    emit_pend_nxt = emit_pend_r;
    if (emit_pend_r && sts.out_free) begin
      cmd.emit = 1'b1;
      emit_pend_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.action == srts_pkg::ACT_LOAD) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res_status = srts_pkg::ST_FULL;
          end else begin
            cmd.load = 1'b1;
            cmd.res_status = srts_pkg::ST_LOADED;
          end
          emit_pend_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.action == srts_pkg::ACT_CLEAR) begin
          cmd.clear = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_status = srts_pkg::ST_CLEARED;
          emit_pend_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.action == srts_pkg::ACT_QUERY) begin
          if (sts.sorted) begin
            cmd.srch_init = 1'b1;
            state_nxt = S_SRCH;
          end else begin
            cmd.sort_init = 1'b1;
            state_nxt = S_SORT_CHK;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SORT_CHK: begin
        if (sts.i_lt_cnt) begin
          cmd.rd_cur = 1'b1;
          state_nxt = S_SORT_CUR;
        end else begin
          cmd.sort_done = 1'b1;
          cmd.srch_init = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SORT_CUR: begin
        cmd.cur_take = 1'b1;
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (sts.gt) begin
          cmd.shift = 1'b1;
          if (sts.j_is_one) begin
            state_nxt = S_SORT_PUT;
          end
        end else begin
          cmd.put = 1'b1;
          state_nxt = S_SORT_CHK;
        end
      end
      S_SORT_PUT: begin
        cmd.put = 1'b1;
        state_nxt = S_SORT_CHK;
      end
      S_SRCH: begin
        if (sts.srch_over) begin
          cmd.set_res = 1'b1;
          cmd.res_status = srts_pkg::ST_NOTFOUND;
          emit_pend_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        priority if (sts.eq) begin
          cmd.set_res = 1'b1;
          cmd.res_status = srts_pkg::ST_FOUND;
          emit_pend_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.lt) begin
          cmd.go_low = 1'b1;
          state_nxt = S_SRCH;
        end else begin
          cmd.go_high = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_pend_r <= emit_pend_nxt;
    end
  end

endmodule

// File: src/srts_dp.sv
module srts_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srts_pkg::in_item_t   in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output srts_pkg::out_item_t  out_data,
  input  srts_pkg::cmd_t       cmd,
  output srts_pkg::sts_t       sts
);

  srts_pkg::in_item_t            item_r;
  srts_pkg::rec_t                cur_r, rd_rec;
  srts_pkg::out_item_t           res_r, res_nxt;
  logic [srts_pkg::CNT_W-1:0]    count_r, i_r;
  logic [srts_pkg::IDX_W-1:0]    j_r;
  logic signed [srts_pkg::POS_W-1:0] low_r, high_r, mid_r, mid_nxt;
  logic                          sorted_r;
  logic                          out_valid_r;
  srts_pkg::out_item_t           out_data_r;
  logic                          we;
  logic [srts_pkg::IDX_W-1:0]    waddr, raddr;
  logic [srts_pkg::REC_W-1:0]    wdata, rdata;

  assign rd_rec = srts_pkg::rec_t'(rdata);
  assign mid_nxt = (low_r + high_r) >>> 1;

  always_comb begin
    we = 1'b0;
    waddr = j_r;
    wdata = cur_r;
    priority if (cmd.load) begin
      we = 1'b1;
      waddr = count_r[srts_pkg::IDX_W-1:0];
      wdata = {item_r.rec_id, item_r.rec_name, item_r.rec_gender, item_r.rec_age};
    end else if (cmd.shift) begin
      we = 1'b1;
      wdata = rdata;
    end else if (cmd.put) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd.rd_cur) begin
      raddr = i_r[srts_pkg::IDX_W-1:0];
    end else if (cmd.cur_take) begin
      raddr = i_r[srts_pkg::IDX_W-1:0] - srts_pkg::IDX_W'(1);
    end else if (cmd.shift) begin
      raddr = j_r - srts_pkg::IDX_W'(2);
    end else begin
      raddr = mid_nxt[srts_pkg::IDX_W-1:0];
    end
  end

  srts_ram #(.WIDTH(srts_pkg::REC_W), .DEPTH(srts_pkg::TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.action    = item_r.action;
    sts.full      = (count_r == srts_pkg::CNT_W'(srts_pkg::TABLE_DEPTH));
    sts.sorted    = sorted_r;
    sts.i_lt_cnt  = (i_r < count_r);
    sts.gt        = (rd_rec.id > cur_r.id);
    sts.j_is_one  = (j_r == srts_pkg::IDX_W'(1));
    sts.srch_over = (low_r > high_r);
    sts.eq        = (rd_rec.id == item_r.rec_id);
    sts.lt        = (rd_rec.id < item_r.rec_id);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // result fields are zero unless a record was found
  always_comb begin
    res_nxt = '0;
    res_nxt.status = cmd.res_status;
    if (cmd.res_status == srts_pkg::ST_FOUND) begin
      res_nxt.out_id = rd_rec.id;
      res_nxt.out_name = rd_rec.name;
      res_nxt.out_gender = rd_rec.gender;
      res_nxt.out_age = rd_rec.age;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.cur_take) begin
      cur_r <= rd_rec;
      j_r <= i_r[srts_pkg::IDX_W-1:0];
    end
    if (cmd.shift) begin
      j_r <= j_r - srts_pkg::IDX_W'(1);
    end
    if (cmd.sort_init) begin
      i_r <= srts_pkg::CNT_W'(1);
    end
    if (cmd.put) begin
      i_r <= i_r + srts_pkg::CNT_W'(1);
    end
    if (cmd.srch_init) begin
      low_r <= '0;
      high_r <= $signed({1'b0, count_r}) - srts_pkg::POS_W'(1);
    end
    if (cmd.probe) begin
      mid_r <= mid_nxt;
    end
    if (cmd.go_low) begin
      low_r <= mid_r + srts_pkg::POS_W'(1);
    end
    if (cmd.go_high) begin
      high_r <= mid_r - srts_pkg::POS_W'(1);
    end
    if (cmd.set_res) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_data_r <= res_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sorted_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        count_r <= count_r + srts_pkg::CNT_W'(1);
        sorted_r <= 1'b0;
      end
      if (cmd.clear) begin
        count_r <= '0;
        sorted_r <= 1'b1;
      end
      if (cmd.sort_done) begin
        sorted_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// File: src/sorted_record_table_search_core.sv
// sorted record table with binary search
// input channel in_valid / in_stall / in_data carries one transaction per
// item: load a record, query by id, or clear the table (action code three
// is dropped with no result)
// result channel out_valid / out_stall / out_data returns one transaction
// per load, query and clear, held in an output register
// throughput: one item at a time; a new input transaction is taken once the
// previous result has been handed to the output register
// load and clear: the result is set in the dispatch state and moved to the
// output register once it is free, and the next item is taken after that
// query on a sorted table: each probe of the single read port of the
// record memory passes through the search and probe states, with at most
// log2(depth)+1 probes
// first query after loads: insertion sort first, each record read and
// compared, larger records shifted up one place, then put; then the search
// reset empties the table and marks it sorted, input is stalled while reset
// is held; the memory needs no clearing pass since only entries below the
// fill count are read
// a stalled result holds out_data steady; the block then waits to emit
module sorted_record_table_search_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srts_pkg::out_item_t out_data
);

  srts_pkg::cmd_t cmd;
  srts_pkg::sts_t sts;

  // sequencer for dispatch, sort and search
  srts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // record memory, pointers and output register
  srts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: src/srts_checker.sv
module srts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input srts_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input srts_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != srts_pkg::ST_FOUND |->
      out_data.out_id == 0 && out_data.out_name == 0 &&
      out_data.out_gender == 0 && out_data.out_age == 0)
    else $error("nonzero fields without a hit");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= srts_pkg::ST_CLEARED)
    else $error("bad status code");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action != srts_pkg::ACT_UNUSED |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind sorted_record_table_search_core srts_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
